>>> hw/rtl/dtp_pkg.sv
// shared types and constants of the date text parser
package dtp_pkg;

  localparam int unsigned NUM_W   = 14;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned SEP_W   = 2;
  localparam int unsigned DIG_W   = 4;

  localparam logic [NUM_W-1:0] NUM_MAX = NUM_W'(9999);
  localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(11);
  localparam logic [SEP_W-1:0] SEP_MAX = SEP_W'(3);
  localparam logic [SEP_W-1:0] SEP_DAY = SEP_W'(0);
  localparam logic [SEP_W-1:0] SEP_MON = SEP_W'(1);
  localparam logic [DIG_W-1:0] DIG_NINE = DIG_W'(9);

  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [NUM_W-1:0] MON_JAN = NUM_W'(1);
  localparam logic [NUM_W-1:0] MON_DEC = NUM_W'(12);
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_NOV = 4'd11;

  localparam logic [4:0] DAYS_28 = 5'd28;
  localparam logic [4:0] DAYS_29 = 5'd29;
  localparam logic [4:0] DAYS_30 = 5'd30;
  localparam logic [4:0] DAYS_31 = 5'd31;

  typedef struct packed {
    logic [NUM_W-1:0] day;
    logic [NUM_W-1:0] month;
    logic [NUM_W-1:0] year;
    logic             cent;
    logic             had_sep;
  } fields_t;

endpackage

>>> hw/rtl/date_text_parse_validate.sv
// top level of the day-month-year date text parser and validator
//
// input channel: valid, ready, ch. one text byte per item; digits build a
// number saturating at 9999, a dot or slash closes the day then the month,
// a zero byte closes the year and ends the date.
// result channel: res_valid, res_ready, day, month, year, valid_res,
// had_separator. one result per zero byte, none for other bytes.
// throughput: one byte per cycle while no held result stalls a zero byte;
// the byte passes an input register, then updates the parse state, and a
// zero byte loads the calendar check of that state into the result register.
// result path: a zero byte passes the input register, then its result is
// loaded into the result register and shown with res_valid.
// stall: a held result blocks only a following zero byte in the input
// register; other bytes keep flowing, so ready drops only then.
// reset: clears the parse state, input register valid and result valid; the
// first byte is taken in the cycle after reset is released.
module date_text_parse_validate (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      valid,
  output logic                      ready,
  input  logic [7:0]                ch,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic [dtp_pkg::NUM_W-1:0] day,
  output logic [dtp_pkg::NUM_W-1:0] month,
  output logic [dtp_pkg::NUM_W-1:0] year,
  output logic                      valid_res,
  output logic                      had_separator
);

  logic             ch_vld;
  logic [7:0]       ch_q;
  logic             go;
  logic             is_end;
  logic             ok;
  dtp_pkg::fields_t cur;

  assign is_end = (ch_q == dtp_pkg::CH_END);
  assign go     = ch_vld && (!is_end || !res_valid || res_ready);
  assign ready  = !ch_vld || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_vld <= 1'b0;
    end else if (ready) begin
      ch_vld <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      ch_q <= ch;
    end
  end

  dtp_accum u_accum (
    .clk  (clk),
    .rst  (rst),
    .take (go),
    .ch   (ch_q),
    .cur  (cur)
  );

  dtp_date_check u_check (
    .cur (cur),
    .ok  (ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (go && is_end) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && is_end) begin
      day           <= cur.day;
      month         <= cur.month;
      year          <= cur.year;
      valid_res     <= ok;
      had_separator <= cur.had_sep;
    end
  end

endmodule

>>> hw/rtl/dtp_accum.sv
// parse state: number accumulator, stored day and month, counters
module dtp_accum (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            ch,
  output dtp_pkg::fields_t      cur
);

  logic [dtp_pkg::NUM_W-1:0] number_accum;
  logic [dtp_pkg::NUM_W-1:0] day_reg;
  logic [dtp_pkg::NUM_W-1:0] month_reg;
  logic [dtp_pkg::SEP_W-1:0] separator_count;
  logic [dtp_pkg::CNT_W-1:0] byte_count;
  logic [dtp_pkg::DIG_W-1:0] dig_hi;
  logic [dtp_pkg::DIG_W-1:0] dig_lo;

  logic                      is_digit;
  logic                      is_sep;
  logic [dtp_pkg::DIG_W-1:0] digit;
  logic [16:0]               prod;
  logic                      sat;

  assign is_digit = (ch >= dtp_pkg::CH_ZERO) && (ch <= dtp_pkg::CH_NINE);
  assign is_sep   = (ch == dtp_pkg::CH_DOT) || (ch == dtp_pkg::CH_SLASH);
  assign digit    = dtp_pkg::DIG_W'(ch - dtp_pkg::CH_ZERO);
  assign prod     = 17'(number_accum) * 17'd10 + 17'(digit);
  assign sat      = prod > 17'(dtp_pkg::NUM_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      number_accum    <= '0;
      day_reg         <= '0;
      month_reg       <= '0;
      separator_count <= '0;
      byte_count      <= '0;
      dig_hi          <= '0;
      dig_lo          <= '0;
    end else if (take) begin
      if (ch == dtp_pkg::CH_END) begin
        number_accum    <= '0;
        day_reg         <= '0;
        month_reg       <= '0;
        separator_count <= '0;
        byte_count      <= '0;
        dig_hi          <= '0;
        dig_lo          <= '0;
      end else if (byte_count < dtp_pkg::MAX_LEN) begin
        byte_count <= byte_count + 1'b1;
        if (is_digit) begin
          if (sat) begin
            number_accum <= dtp_pkg::NUM_MAX;
            dig_hi       <= dtp_pkg::DIG_NINE;
            dig_lo       <= dtp_pkg::DIG_NINE;
          end else begin
            number_accum <= prod[dtp_pkg::NUM_W-1:0];
            dig_hi       <= dig_lo;
            dig_lo       <= digit;
          end
        end else if (is_sep) begin
          if (separator_count == dtp_pkg::SEP_DAY) begin
            day_reg <= number_accum;
          end else if (separator_count == dtp_pkg::SEP_MON) begin
            month_reg <= number_accum;
          end
          if (separator_count != dtp_pkg::SEP_MAX) begin
            separator_count <= separator_count + 1'b1;
          end
          number_accum <= '0;
          dig_hi       <= '0;
          dig_lo       <= '0;
        end
      end
    end
  end

  // last two decimal digits track year % 100
  assign cur.day     = day_reg;
  assign cur.month   = month_reg;
  assign cur.year    = number_accum;
  assign cur.cent    = (dig_hi == '0) && (dig_lo == '0);
  assign cur.had_sep = (separator_count != '0);

endmodule

>>> hw/rtl/dtp_date_check.sv
// gregorian calendar check of day, month and year
module dtp_date_check (
  input  dtp_pkg::fields_t cur,
  output logic             ok
);

  logic       leap;
  logic       mon_ok;
  logic [4:0] lim;

  // divisible by 400 means divisible by 100 and by 16
  assign leap   = (cur.year[1:0] == 2'b00) &&
                  (!cur.cent || (cur.year[3:0] == 4'b0000));
  assign mon_ok = (cur.month >= dtp_pkg::MON_JAN) && (cur.month <= dtp_pkg::MON_DEC);

  always_comb begin
    case (cur.month[3:0])
      dtp_pkg::MON_FEB: lim = leap ? dtp_pkg::DAYS_29 : dtp_pkg::DAYS_28;
      dtp_pkg::MON_APR,
      dtp_pkg::MON_JUN,
      dtp_pkg::MON_SEP,
      dtp_pkg::MON_NOV: lim = dtp_pkg::DAYS_30;
      default:          lim = dtp_pkg::DAYS_31;
    endcase
  end

  assign ok = mon_ok && (cur.day != '0) && (cur.day <= dtp_pkg::NUM_W'(lim));

endmodule
